// File: rtl/mrrb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Multi-reader ring buffer package
// Command and status codes, stream word layout and the control and status
// bundles exchanged between the controller and the datapath.
// ----------------------------------------------------------------------------
package mrrb_pkg;

    localparam int CMD_W      = 2;
    localparam int STAT_W     = 2;
    localparam int CFG_W      = 4;
    localparam int RI_W       = 3;
    localparam int VC_W       = 16;
    localparam int SI_W       = 4;
    localparam int FIELD_W    = 4;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 40;

    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;
    localparam logic [STAT_W-1:0] STAT_BAD   = 2'd3;

    typedef struct packed {
        logic load;
        logic rd_ri;
        logic cap;
        logic issue;
        logic fold;
        logic commit;
        logic rd_slot;
        logic out_load;
    } t_ctl;

    typedef struct packed {
        logic scan_more;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

// File: rtl/multi_reader_ring_buffer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Multi-reader ring buffer
// Broadcast ring of slot vertex counts with one writer and several readers.
// ----------------------------------------------------------------------------
// Each input word is a query, a writer commit or a reader commit, and each
// gives exactly one result word that shows the state after the command. The
// free-slot minimum is found by reading one reader pointer per cycle from
// the pointer memory, over active_readers limited to NUM_READERS readers.
// Only one word is in work at a time; the input is ready again once its
// result sits in the output register, and a result that is not yet taken
// holds the next one back. No clearing pass follows reset.
module multi_reader_ring_buffer #(
    parameter int SLOTS       = 16,
    parameter int NUM_READERS = 8
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    // active_readers [3:0]
    input  wire logic [mrrb_pkg::CFG_W-1:0]        i_cfg_data,
    input  wire logic                              i_s_tvalid,
    output logic                                   o_s_tready,
    // reader_index [2:0], vertex_count [18:3], slot_index [22:19], zero [23]
    input  wire logic [mrrb_pkg::S_TDATA_W-1:0]    i_s_tdata,
    // cmd [1:0]
    input  wire logic [mrrb_pkg::CMD_W-1:0]        i_s_tuser,
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    // writer_slot_valid [0], writer_slot [4:1], reader_slot_valid [5],
    // reader_slot [9:6], free_slots [13:10], all_drained [14],
    // slot_vertices [30:15], wake_readers [31], wake_writer [32], zero [39:33]
    output logic [mrrb_pkg::M_TDATA_W-1:0]         o_m_tdata,
    // status [1:0]
    output logic [mrrb_pkg::STAT_W-1:0]            o_m_tuser
);
    import mrrb_pkg::*;

    t_ctl ctl;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    mrrb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_ctl      (ctl)
    );

    mrrb_dp #(
        .SLOTS       (SLOTS),
        .NUM_READERS (NUM_READERS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_m_tready  (i_m_tready),
        .i_ctl       (ctl),
        .o_sts       (sts),
        .o_m_tvalid  (o_m_tvalid),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

endmodule
`default_nettype wire

// File: rtl/mrrb_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Multi-reader ring buffer controller
// Sequences one word through reader lookup, pointer scan, commit, slot read
// and result hand-off.
// ----------------------------------------------------------------------------
module mrrb_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_tvalid,
    output logic               o_s_tready,
    input  wire mrrb_pkg::t_sts i_sts,
    output mrrb_pkg::t_ctl     o_ctl
);
    import mrrb_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_RDR    = 3'd1;
    localparam logic [2:0] S_CAP    = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_COMMIT = 3'd4;
    localparam logic [2:0] S_RDS    = 3'd5;
    localparam logic [2:0] S_OUT    = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_fold;
    logic       n_fold;

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_ctl.load = i_s_tvalid;
                if (i_s_tvalid) begin
                    n_state = S_RDR;
                end
            end
            S_RDR: begin
                o_ctl.rd_ri = 1'b1;
                n_state     = S_CAP;
            end
            S_CAP: begin
                o_ctl.cap   = 1'b1;
                o_ctl.issue = i_sts.scan_more;
                n_state     = S_SCAN;
            end
            S_SCAN: begin
                o_ctl.issue = i_sts.scan_more;
                o_ctl.fold  = r_fold;
                if (!i_sts.scan_more) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                o_ctl.commit = 1'b1;
                n_state      = S_RDS;
            end
            S_RDS: begin
                o_ctl.rd_slot = 1'b1;
                n_state       = S_OUT;
            end
            S_OUT: begin
                o_ctl.out_load = i_sts.out_free;
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_fold     = o_ctl.issue;
    assign o_s_tready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fold  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fold  <= n_fold;
        end
    end

endmodule
`default_nettype wire

// File: rtl/mrrb_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Multi-reader ring buffer datapath
// Holds the pointers, the reader pointer and slot count memories, the
// running free-slot minimum and the result register.
// ----------------------------------------------------------------------------
module mrrb_dp #(
    parameter int SLOTS       = 16,
    parameter int NUM_READERS = 8
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_valid,
    input  wire logic [mrrb_pkg::CFG_W-1:0]        i_cfg_data,
    input  wire logic [mrrb_pkg::S_TDATA_W-1:0]    i_s_tdata,
    input  wire logic [mrrb_pkg::CMD_W-1:0]        i_s_tuser,
    input  wire logic                              i_m_tready,
    input  wire mrrb_pkg::t_ctl                    i_ctl,
    output mrrb_pkg::t_sts                         o_sts,
    output logic                                   o_m_tvalid,
    output logic [mrrb_pkg::M_TDATA_W-1:0]         o_m_tdata,
    output logic [mrrb_pkg::STAT_W-1:0]            o_m_tuser
);
    import mrrb_pkg::*;

    localparam int PW = $clog2(SLOTS);
    localparam int RW = (NUM_READERS > 1) ? $clog2(NUM_READERS) : 1;
    localparam int CW = $clog2(NUM_READERS + 1);
    localparam int SW = (PW > SI_W) ? PW : SI_W;
    localparam int IW = (RW > RI_W) ? RW : RI_W;
    localparam logic [PW:0]   SLOTS_W = (PW + 1)'(SLOTS);
    localparam logic [PW-1:0] LAST    = PW'(SLOTS - 1);

    function automatic logic [PW-1:0] advance(input logic [PW-1:0] p);
        logic [PW-1:0] q;
        q = PW'(p + 1'b1);
        return (p == LAST) ? '0 : q;
    endfunction

    function automatic logic [PW-1:0] fill(input logic [PW-1:0] w, input logic [PW-1:0] r);
        logic [PW:0] d;
        if (r <= w) begin
            d = {1'b0, w} - {1'b0, r};
        end else begin
            d = {1'b0, w} + SLOTS_W - {1'b0, r};
        end
        return d[PW-1:0];
    endfunction

    logic [CFG_W-1:0]        r_active;
    logic [CMD_W-1:0]        r_cmd;
    logic [RI_W-1:0]         r_ri;
    logic [VC_W-1:0]         r_vc;
    logic [SI_W-1:0]         r_si;
    logic [PW-1:0]           r_wp;
    logic [PW-1:0]           r_rp_ri;
    logic [PW-1:0]           r_min;
    logic [CW-1:0]           r_scan_idx;
    logic [RW-1:0]           r_fold_idx;
    logic [STAT_W-1:0]       r_status;
    logic                    r_wake_r;
    logic                    r_wake_w;
    logic [PW-1:0]           r_rp_mem [NUM_READERS];
    logic [NUM_READERS-1:0]  r_rp_vld;
    logic [PW-1:0]           r_rp_rd;
    logic                    r_rp_rd_vld;
    logic [VC_W-1:0]         r_slot_mem [SLOTS];
    logic [SLOTS-1:0]        r_slot_vld;
    logic [VC_W-1:0]         r_sl_rd;
    logic                    r_sl_rd_vld;
    logic                    r_m_tvalid;
    logic [M_TDATA_W-1:0]    r_m_tdata;
    logic [STAT_W-1:0]       r_m_tuser;

    logic [STAT_W-1:0]       n_status;
    logic                    n_wake_r;
    logic                    n_wake_w;
    logic [CW-1:0]           n_act;
    logic [IW-1:0]           ri_w;
    logic [RW-1:0]           ri_addr;
    logic                    reader_ok;
    logic                    proceed;
    logic [PW-1:0]           rp_rd_val;
    logic [PW-1:0]           rp_eff;
    logic [PW-1:0]           avail;
    logic [RW-1:0]           rd_addr;
    logic [SW-1:0]           si_w;
    logic [PW-1:0]           si_addr;
    logic                    si_in;
    logic                    wr_ok;
    logic                    rd_ok;
    logic                    wsv;
    logic                    rsv;
    logic [SW-1:0]           wp_w;
    logic [SW-1:0]           rp_w;
    logic [SW-1:0]           fr_w;
    logic [VC_W-1:0]         sv;
    logic [M_TDATA_W-1:0]    n_m_tdata;

    always_comb begin
        if (32'(r_active) > NUM_READERS) begin
            n_act = CW'(NUM_READERS);
        end else begin
            n_act = CW'(r_active);
        end
    end

    assign ri_w      = IW'(r_ri);
    assign ri_addr   = ri_w[RW-1:0];
    assign reader_ok = (32'(r_ri) < 32'(n_act));
    assign proceed   = reader_ok && (r_rp_ri != r_wp);
    assign rp_rd_val = r_rp_rd_vld ? r_rp_rd : '0;
    assign rp_eff    = ((r_cmd == CMD_READ) && proceed && (r_fold_idx == ri_addr))
                       ? advance(r_rp_ri) : rp_rd_val;
    assign avail     = LAST - fill(r_wp, rp_eff);
    assign rd_addr   = i_ctl.issue ? r_scan_idx[RW-1:0] : ri_addr;
    assign si_w      = SW'(r_si);
    assign si_addr   = si_w[PW-1:0];
    assign si_in     = (32'(r_si) < SLOTS);
    assign wr_ok     = i_ctl.commit && (r_cmd == CMD_WRITE) && (r_min != '0);
    assign rd_ok     = i_ctl.commit && (r_cmd == CMD_READ) && proceed;

    assign o_sts.scan_more = (r_scan_idx < n_act);
    assign o_sts.out_free  = !r_m_tvalid || i_m_tready;

    always_comb begin
        n_status = STAT_OK;
        n_wake_r = 1'b0;
        n_wake_w = 1'b0;
        case (r_cmd)
            CMD_WRITE: begin
                if (r_min == '0) begin
                    n_status = STAT_FULL;
                end else begin
                    n_wake_r = (n_act != '0);
                end
            end
            CMD_READ: begin
                if (!reader_ok) begin
                    n_status = STAT_BAD;
                end else if (r_rp_ri == r_wp) begin
                    n_status = STAT_EMPTY;
                end else begin
                    n_wake_w = (r_min == LAST);
                end
            end
            default: begin
                if (!reader_ok) begin
                    n_status = STAT_BAD;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.issue || i_ctl.rd_ri) begin
            r_rp_rd     <= r_rp_mem[rd_addr];
            r_rp_rd_vld <= r_rp_vld[rd_addr];
        end
        if (rd_ok) begin
            r_rp_mem[ri_addr] <= advance(r_rp_ri);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_slot) begin
            r_sl_rd     <= r_slot_mem[si_addr];
            r_sl_rd_vld <= r_slot_vld[si_addr];
        end
        if (wr_ok) begin
            r_slot_mem[r_wp] <= r_vc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= '0;
            r_wp       <= '0;
            r_rp_vld   <= '0;
            r_slot_vld <= '0;
            r_m_tvalid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_active <= i_cfg_data;
            end
            if (wr_ok) begin
                r_wp             <= advance(r_wp);
                r_slot_vld[r_wp] <= 1'b1;
            end
            if (rd_ok) begin
                r_rp_vld[ri_addr] <= 1'b1;
            end
            if (i_ctl.out_load) begin
                r_m_tvalid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_tvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd      <= i_s_tuser;
            r_ri       <= i_s_tdata[2:0];
            r_vc       <= i_s_tdata[18:3];
            r_si       <= i_s_tdata[22:19];
            r_scan_idx <= '0;
            r_min      <= LAST;
        end
        if (i_ctl.cap) begin
            r_rp_ri <= rp_rd_val;
        end
        if (i_ctl.issue) begin
            r_scan_idx <= CW'(r_scan_idx + 1'b1);
            r_fold_idx <= r_scan_idx[RW-1:0];
        end
        if (i_ctl.fold && (avail < r_min)) begin
            r_min <= avail;
        end
        if (i_ctl.commit) begin
            r_status <= n_status;
            r_wake_r <= n_wake_r;
            r_wake_w <= n_wake_w;
            if (wr_ok && (n_act != '0)) begin
                r_min <= PW'(r_min - 1'b1);
            end
            if (rd_ok) begin
                r_rp_ri <= advance(r_rp_ri);
            end
        end
        if (i_ctl.out_load) begin
            r_m_tdata <= n_m_tdata;
            r_m_tuser <= r_status;
        end
    end

    assign wsv  = (r_min != '0);
    assign rsv  = reader_ok && (r_rp_ri != r_wp);
    assign wp_w = wsv ? SW'(r_wp) : '0;
    assign rp_w = rsv ? SW'(r_rp_ri) : '0;
    assign fr_w = SW'(r_min);
    assign sv   = (si_in && r_sl_rd_vld) ? r_sl_rd : '0;

    assign n_m_tdata = {7'd0, r_wake_w, r_wake_r, sv, (r_min == LAST), fr_w[FIELD_W-1:0],
                        rp_w[FIELD_W-1:0], rsv, wp_w[FIELD_W-1:0], wsv};

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;
    assign o_m_tuser  = r_m_tuser;

endmodule
`default_nettype wire

// File: rtl/mrrb_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Multi-reader ring buffer checker
// Port-level properties of the ring buffer, bound to the top level.
// ----------------------------------------------------------------------------
module mrrb_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              i_s_tvalid,
    input wire logic                              o_s_tready,
    input wire logic                              o_m_tvalid,
    input wire logic                              i_m_tready,
    input wire logic [mrrb_pkg::M_TDATA_W-1:0]    o_m_tdata,
    input wire logic [mrrb_pkg::STAT_W-1:0]       o_m_tuser
);
    import mrrb_pkg::*;

    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input accepted while a word is in work");

    a_wake_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tdata[31] && o_m_tdata[32]))
        else $error("both wake pulses in one result");

    a_wake_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tdata[31] || o_m_tdata[32])) |-> (o_m_tuser == STAT_OK))
        else $error("wake pulse on a failed command");

    a_drained_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[14]) |-> o_m_tdata[0])
        else $error("drained ring reports no writer slot");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled result word changed");

endmodule

bind multi_reader_ring_buffer mrrb_checker u_mrrb_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
`default_nettype wire
